>>> rtl/wps_pkg.sv
// Package: widths, codes, entry type and helpers for the waypoint sequencer.
package wps_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int COORD_BITS    = 24;

    localparam int OP_W     = 2;
    localparam int ENTRY_W  = 6;
    localparam int TOL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
    localparam int MAG_W = (COORD_BITS + 1 > TOL_W) ? COORD_BITS + 1 : TOL_W;
    localparam int SUM_W = 2 * MAG_W + 1;
    localparam int SQ_CNT_W = $clog2(MAG_W);

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_POS     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_TRACK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ARRIVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PROMOTE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FINISH  = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [MAG_W-1:0]             t_mag;
    typedef logic [SUM_W-1:0]             t_sum;

    typedef struct packed {
        t_coord           x;
        t_coord           y;
        logic [TOL_W-1:0] tol;
    } t_entry;

    typedef struct packed {
        logic start;
        t_mag mag_a;
        t_mag mag_b;
    } t_sq_req;

    function automatic t_mag abs_diff(t_coord a, t_coord b);
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? -d : d;
        return t_mag'(unsigned'(m));
    endfunction

endpackage

>>> rtl/wps_sqsum.sv
// Bit-serial sum of two squares: mag_a^2 + mag_b^2, one multiplier bit per cycle.
module wps_sqsum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wps_pkg::t_sq_req i_req,
    output logic            o_done,
    output wps_pkg::t_sum   o_sum
);

    logic                         r_busy;
    logic                         r_add;
    logic                         r_done;
    logic [wps_pkg::SQ_CNT_W-1:0] r_cnt;
    wps_pkg::t_mag                r_mc_a, r_mc_b;
    wps_pkg::t_mag                r_mq_a, r_mq_b;
    wps_pkg::t_mag                r_hi_a, r_hi_b;
    wps_pkg::t_mag                r_lo_a, r_lo_b;
    wps_pkg::t_sum                r_sum;

    logic [wps_pkg::MAG_W:0] n_s_a, n_s_b;

    assign n_s_a = {1'b0, r_hi_a} + (r_mq_a[0] ? {1'b0, r_mc_a} : '0);
    assign n_s_b = {1'b0, r_hi_b} + (r_mq_b[0] ? {1'b0, r_mc_b} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_add  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == wps_pkg::SQ_CNT_W'(wps_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_add  <= 1'b1;
                end
            end else if (r_add) begin
                r_add  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mc_a <= i_req.mag_a;
            r_mq_a <= i_req.mag_a;
            r_mc_b <= i_req.mag_b;
            r_mq_b <= i_req.mag_b;
            r_hi_a <= '0;
            r_lo_a <= '0;
            r_hi_b <= '0;
            r_lo_b <= '0;
        end else if (r_busy) begin
            r_hi_a <= n_s_a[wps_pkg::MAG_W:1];
            r_lo_a <= {n_s_a[0], r_lo_a[wps_pkg::MAG_W-1:1]};
            r_mq_a <= r_mq_a >> 1;
            r_hi_b <= n_s_b[wps_pkg::MAG_W:1];
            r_lo_b <= {n_s_b[0], r_lo_b[wps_pkg::MAG_W-1:1]};
            r_mq_b <= r_mq_b >> 1;
        end
        if (r_add) begin
            r_sum <= {1'b0, r_hi_a, r_lo_a} + {1'b0, r_hi_b, r_lo_b};
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

>>> rtl/waypoint_sequencer.sv
// Top level: waypoint table, route sequencer and result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------------
//  input    | i_in_valid / o_in_stall    | i_op, i_entry_index, i_coord_x/y, i_tolerance
//  output   | o_out_valid / i_out_stall  | o_status, o_target_index, o_target_x/y/tolerance
//  config   | i_cfg_we                   | i_cfg_data (waypoint_count)
//
// Load, restart and unused ops return to S_IDLE with no result; a finished route goes to S_OUT.
// A position item squares its distance to the current entry and that entry's tolerance, reads
// the following entry on arrival, and squares two more distances when the next waypoint is
// checked, all on the bit-serial squaring unit shared by all four distance terms.
// Synchronous reset clears control state; the table is undefined until loaded.
// A stalled result holds the next position item at its final write, which stalls the input.
module waypoint_sequencer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [wps_pkg::OP_W-1:0]              i_op,
    input  logic [wps_pkg::ENTRY_W-1:0]           i_entry_index,
    input  logic signed [wps_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [wps_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic [wps_pkg::TOL_W-1:0]             i_tolerance,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [wps_pkg::STATUS_W-1:0]          o_status,
    output logic [wps_pkg::ENTRY_W-1:0]           o_target_index,
    output logic signed [wps_pkg::COORD_BITS-1:0] o_target_x,
    output logic signed [wps_pkg::COORD_BITS-1:0] o_target_y,
    output logic [wps_pkg::TOL_W-1:0]             o_target_tolerance,
    input  logic                                  i_cfg_we,
    input  logic [wps_pkg::CFG_W-1:0]             i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD_W0  = 4'd1;
    localparam logic [3:0] S_W0     = 4'd2;
    localparam logic [3:0] S_D0     = 4'd3;
    localparam logic [3:0] S_TOL    = 4'd4;
    localparam logic [3:0] S_RD_W1  = 4'd5;
    localparam logic [3:0] S_W1     = 4'd6;
    localparam logic [3:0] S_D1     = 4'd7;
    localparam logic [3:0] S_D01    = 4'd8;
    localparam logic [3:0] S_RD_OUT = 4'd9;
    localparam logic [3:0] S_W_OUT  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]                    r_state;
    logic [wps_pkg::CFG_W-1:0]     r_count;
    logic [wps_pkg::CNT_W-1:0]     r_idx;
    logic                          r_started;
    logic                          r_finished;
    logic [wps_pkg::STATUS_W-1:0]  r_status;
    wps_pkg::t_coord               r_px, r_py;
    wps_pkg::t_entry               r_w0, r_w1, r_tgt;
    wps_pkg::t_sum                 r_d0, r_d1;
    logic [wps_pkg::IDX_W-1:0]     r_rd_addr;
    wps_pkg::t_entry               r_rd_data;
    wps_pkg::t_entry               r_mem [wps_pkg::MAX_WAYPOINTS];
    wps_pkg::t_sq_req              r_sq_req;
    logic                          r_out_valid;
    logic [wps_pkg::STATUS_W-1:0]  r_out_status;
    logic [wps_pkg::ENTRY_W-1:0]   r_out_index;
    wps_pkg::t_entry               r_out_entry;

    logic                          n_accept;
    logic                          n_out_free;
    logic [wps_pkg::CNT_W-1:0]     n_active;
    logic [wps_pkg::CNT_W-1:0]     n_idx_inc;
    logic [wps_pkg::CNT_W-1:0]     n_start_idx;
    logic                          n_sq_done;
    wps_pkg::t_sum                 n_sq_sum;

    assign o_in_stall  = (r_state != S_IDLE);
    assign n_accept    = i_in_valid && (r_state == S_IDLE);
    assign n_out_free  = !r_out_valid || !i_out_stall;
    assign n_active    = (int'(r_count) > wps_pkg::MAX_WAYPOINTS)
                       ? wps_pkg::CNT_W'(wps_pkg::MAX_WAYPOINTS)
                       : wps_pkg::CNT_W'(r_count);
    assign n_idx_inc   = r_idx + 1'b1;
    assign n_start_idx = r_started ? r_idx : '0;

    wps_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_sq_req),
        .o_done  (n_sq_done),
        .o_sum   (n_sq_sum)
    );

    // waypoint table
    always_ff @(posedge i_clk) begin
        if (n_accept && i_op == wps_pkg::OP_LOAD
                && int'(i_entry_index) < wps_pkg::MAX_WAYPOINTS) begin
            r_mem[wps_pkg::IDX_W'(i_entry_index)] <= '{x: i_coord_x, y: i_coord_y,
                                                       tol: i_tolerance};
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sq_req    <= '0;
        end else begin
            r_sq_req.start <= 1'b0;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_px <= i_coord_x;
                        r_py <= i_coord_y;
                        unique case (i_op)
                            wps_pkg::OP_RESTART: begin
                                r_idx      <= '0;
                                r_started  <= 1'b0;
                                r_finished <= 1'b0;
                            end
                            wps_pkg::OP_POS: begin
                                if (r_finished) begin
                                    r_status <= wps_pkg::ST_FINISH;
                                    r_tgt    <= '0;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_started <= 1'b1;
                                    r_idx     <= n_start_idx;
                                    if (n_start_idx >= n_active) begin
                                        r_finished <= 1'b1;
                                        r_status   <= wps_pkg::ST_FINISH;
                                        r_tgt      <= '0;
                                        r_state    <= S_OUT;
                                    end else begin
                                        r_rd_addr <= n_start_idx[wps_pkg::IDX_W-1:0];
                                        r_state   <= S_RD_W0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_W0: r_state <= S_W0;
                S_W0: begin
                    r_w0           <= r_rd_data;
                    r_sq_req.start <= 1'b1;
                    r_sq_req.mag_a <= wps_pkg::abs_diff(r_px, r_rd_data.x);
                    r_sq_req.mag_b <= wps_pkg::abs_diff(r_py, r_rd_data.y);
                    r_state        <= S_D0;
                end
                S_D0: begin
                    if (n_sq_done) begin
                        r_d0           <= n_sq_sum;
                        r_sq_req.start <= 1'b1;
                        r_sq_req.mag_a <= wps_pkg::MAG_W'(r_w0.tol);
                        r_sq_req.mag_b <= '0;
                        r_state        <= S_TOL;
                    end
                end
                S_TOL: begin
                    if (n_sq_done) begin
                        if (r_d0 < n_sq_sum) begin
                            r_idx <= n_idx_inc;
                            if (n_idx_inc >= n_active) begin
                                r_finished <= 1'b1;
                                r_status   <= wps_pkg::ST_FINISH;
                                r_tgt      <= '0;
                                r_state    <= S_OUT;
                            end else begin
                                r_status  <= wps_pkg::ST_ARRIVED;
                                r_rd_addr <= n_idx_inc[wps_pkg::IDX_W-1:0];
                                r_state   <= S_RD_OUT;
                            end
                        end else if (n_idx_inc < n_active) begin
                            r_rd_addr <= n_idx_inc[wps_pkg::IDX_W-1:0];
                            r_state   <= S_RD_W1;
                        end else begin
                            r_status <= wps_pkg::ST_TRACK;
                            r_tgt    <= r_w0;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_RD_W1: r_state <= S_W1;
                S_W1: begin
                    r_w1           <= r_rd_data;
                    r_sq_req.start <= 1'b1;
                    r_sq_req.mag_a <= wps_pkg::abs_diff(r_px, r_rd_data.x);
                    r_sq_req.mag_b <= wps_pkg::abs_diff(r_py, r_rd_data.y);
                    r_state        <= S_D1;
                end
                S_D1: begin
                    if (n_sq_done) begin
                        r_d1           <= n_sq_sum;
                        r_sq_req.start <= 1'b1;
                        r_sq_req.mag_a <= wps_pkg::abs_diff(r_w0.x, r_w1.x);
                        r_sq_req.mag_b <= wps_pkg::abs_diff(r_w0.y, r_w1.y);
                        r_state        <= S_D01;
                    end
                end
                S_D01: begin
                    if (n_sq_done) begin
                        if (r_d1 < n_sq_sum) begin
                            r_idx    <= n_idx_inc;
                            r_status <= wps_pkg::ST_PROMOTE;
                            r_tgt    <= r_w1;
                        end else begin
                            r_status <= wps_pkg::ST_TRACK;
                            r_tgt    <= r_w0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_RD_OUT: r_state <= S_W_OUT;
                S_W_OUT: begin
                    r_tgt   <= r_rd_data;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && n_out_free) begin
            r_out_status <= r_status;
            r_out_index  <= (r_status == wps_pkg::ST_FINISH) ? '0
                                                             : wps_pkg::ENTRY_W'(r_idx);
            r_out_entry  <= r_tgt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_target_index     = r_out_index;
    assign o_target_x         = r_out_entry.x;
    assign o_target_y         = r_out_entry.y;
    assign o_target_tolerance = r_out_entry.tol;

    a_finished_started : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> r_started)
        else $error("route finished without having started");

    a_sq_done_waited : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_sq_done |-> (r_state == S_D0 || r_state == S_TOL ||
                       r_state == S_D1 || r_state == S_D01))
        else $error("distance result arrived outside a wait state");

    a_target_in_route : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status != wps_pkg::ST_FINISH) |-> (r_idx < n_active))
        else $error("reported target lies beyond the active route");

endmodule

>>> bench/waypoint_sequencer_tb.sv
// Self-checking testbench for waypoint_sequencer: drives route items and checks each fix result.
`timescale 1ns / 100ps

module waypoint_sequencer_tb;

    localparam logic [wps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_PRINTS    = 40;
    localparam int TIMEOUT_NS    = 6_000_000;

    localparam wps_pkg::t_coord COORD_MAX = {1'b0, {(wps_pkg::COORD_BITS-1){1'b1}}};
    localparam wps_pkg::t_coord COORD_MIN = {1'b1, {(wps_pkg::COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [wps_pkg::STATUS_W-1:0] status;
        logic [wps_pkg::ENTRY_W-1:0]  index;
        wps_pkg::t_coord              x;
        wps_pkg::t_coord              y;
        logic [wps_pkg::TOL_W-1:0]    tol;
    } t_fix_result;

    class route_scoreboard;
        wps_pkg::t_entry route_tab [wps_pkg::MAX_WAYPOINTS];
        bit              loaded [wps_pkg::MAX_WAYPOINTS];
        int unsigned     cur_idx;
        bit              started;
        bit              finished;
        int unsigned     wp_count;
        t_fix_result     pending [$];
        int              errors;

        function int unsigned active_count();
            return (wp_count > wps_pkg::MAX_WAYPOINTS) ? wps_pkg::MAX_WAYPOINTS : wp_count;
        endfunction

        // entry the next fix is measured against
        function int unsigned next_target();
            return started ? cur_idx : 0;
        endfunction

        function longint dist_sq(wps_pkg::t_coord ax, wps_pkg::t_coord ay,
                                 wps_pkg::t_coord bx, wps_pkg::t_coord by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return dx * dx + dy * dy;
        endfunction

        function void predict_fix(wps_pkg::t_coord px, wps_pkg::t_coord py);
            t_fix_result                  r;
            wps_pkg::t_entry              w0;
            wps_pkg::t_entry              w1;
            int unsigned                  n;
            logic [wps_pkg::STATUS_W-1:0] st;
            n  = active_count();
            st = wps_pkg::ST_TRACK;
            if (!finished) begin
                if (!started) begin
                    started = 1'b1;
                    cur_idx = 0;
                end
                if (cur_idx >= n) begin
                    finished = 1'b1;
                end else begin
                    w0 = route_tab[cur_idx];
                    if (dist_sq(px, py, w0.x, w0.y) < longint'(w0.tol) * longint'(w0.tol)) begin
                        cur_idx++;
                        if (cur_idx >= n) finished = 1'b1;
                        else st = wps_pkg::ST_ARRIVED;
                    end else if (cur_idx + 1 < n) begin
                        w1 = route_tab[cur_idx + 1];
                        if (dist_sq(px, py, w1.x, w1.y) < dist_sq(w0.x, w0.y, w1.x, w1.y)) begin
                            cur_idx++;
                            st = wps_pkg::ST_PROMOTE;
                        end
                    end
                end
            end
            r = '0;
            if (finished) begin
                r.status = wps_pkg::ST_FINISH;
            end else begin
                w0       = route_tab[cur_idx];
                r.status = st;
                r.index  = wps_pkg::ENTRY_W'(cur_idx);
                r.x      = w0.x;
                r.y      = w0.y;
                r.tol    = w0.tol;
            end
            pending.push_back(r);
        endfunction

        function void note_input(logic [wps_pkg::OP_W-1:0] op,
                                 logic [wps_pkg::ENTRY_W-1:0] slot,
                                 wps_pkg::t_coord px, wps_pkg::t_coord py,
                                 logic [wps_pkg::TOL_W-1:0] ptol);
            case (op)
                wps_pkg::OP_LOAD: begin
                    route_tab[slot] = '{x: px, y: py, tol: ptol};
                    loaded[slot]    = 1'b1;
                end
                wps_pkg::OP_RESTART: begin
                    cur_idx  = 0;
                    started  = 1'b0;
                    finished = 1'b0;
                end
                wps_pkg::OP_POS: predict_fix(px, py);
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_result(t_fix_result got);
            t_fix_result want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing expected, status %0d index %0d",
                                 got.status, got.index));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.index !== want.index)
                report($sformatf("target_index got %0d want %0d", got.index, want.index));
            if (got.x !== want.x)
                report($sformatf("target_x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("target_y got %0d want %0d", got.y, want.y));
            if (got.tol !== want.tol)
                report($sformatf("target_tolerance got %0d want %0d", got.tol, want.tol));
        endtask
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [wps_pkg::OP_W-1:0]     i_op;
    logic [wps_pkg::ENTRY_W-1:0]  i_entry_index;
    wps_pkg::t_coord              i_coord_x;
    wps_pkg::t_coord              i_coord_y;
    logic [wps_pkg::TOL_W-1:0]    i_tolerance;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [wps_pkg::STATUS_W-1:0] o_status;
    logic [wps_pkg::ENTRY_W-1:0]  o_target_index;
    wps_pkg::t_coord              o_target_x;
    wps_pkg::t_coord              o_target_y;
    logic [wps_pkg::TOL_W-1:0]    o_target_tolerance;
    logic                         i_cfg_we;
    logic [wps_pkg::CFG_W-1:0]    i_cfg_data;

    route_scoreboard sb;
    int              burst_left;
    bit              hold_req = 1'b0;
    int unsigned     phase_counts [8] = '{2, 64, 1, 9, 0, 64, 33, 5};

    waypoint_sequencer u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_entry_index      (i_entry_index),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_tolerance        (i_tolerance),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_target_index     (o_target_index),
        .o_target_x         (o_target_x),
        .o_target_y         (o_target_y),
        .o_target_tolerance (o_target_tolerance),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("waypoint_sequencer test failed");
        $finish;
    end

    // receiver: random stall segments, plus a long hold on request
    initial begin
        int hold_left;
        int seg_left;
        int stall_pct;
        hold_left = 0;
        seg_left  = 0;
        stall_pct = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_result({o_status, o_target_index, o_target_x, o_target_y,
                             o_target_tolerance});
    end

    function automatic wps_pkg::t_coord clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return wps_pkg::t_coord'(v);
    endfunction

    function automatic wps_pkg::t_coord offset_coord(wps_pkg::t_coord c, int unsigned spread);
        return clamp_coord(longint'(c) + longint'($urandom_range(0, 2 * spread))
                           - longint'(spread));
    endfunction

    function automatic wps_pkg::t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4, 5: return wps_pkg::t_coord'(int'($urandom_range(0, 8191)) - 4096);
            default: return wps_pkg::t_coord'($urandom);
        endcase
    endfunction

    function automatic logic [wps_pkg::TOL_W-1:0] rand_tol();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return wps_pkg::TOL_W'($urandom_range(1, 255));
            default: return wps_pkg::TOL_W'($urandom);
        endcase
    endfunction

    task automatic drive_item(logic [wps_pkg::OP_W-1:0] op, logic [wps_pkg::ENTRY_W-1:0] slot,
                              wps_pkg::t_coord px, wps_pkg::t_coord py,
                              logic [wps_pkg::TOL_W-1:0] ptol);
        int gap;
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_index <= slot;
        i_coord_x     <= px;
        i_coord_y     <= py;
        i_tolerance   <= ptol;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(op, slot, px, py, ptol);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 19) == 0) gap = $urandom_range(30, 60);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_route();
        for (int s = 0; s < sb.active_count(); s++)
            if (!sb.loaded[s]) drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'(s), rand_coord(),
                                          rand_coord(), rand_tol());
    endtask

    task automatic write_count(int unsigned value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= wps_pkg::CFG_W'(value);
        @(posedge i_clk);
        sb.wp_count = value;
        i_cfg_we <= 1'b0;
        fill_route();
    endtask

    // aims most fixes at the current target or the one after it
    task automatic send_fix();
        wps_pkg::t_entry cur_wp;
        wps_pkg::t_entry next_wp;
        int unsigned     tgt;
        int unsigned     pick;
        int unsigned     reach;
        wps_pkg::t_coord px;
        wps_pkg::t_coord py;
        tgt  = sb.next_target();
        pick = $urandom_range(0, 9);
        px   = rand_coord();
        py   = rand_coord();
        if (!sb.finished && tgt < sb.active_count()) begin
            cur_wp = sb.route_tab[tgt];
            if (pick < 4) begin
                reach = int'(cur_wp.tol) * 7 / 10;
                px    = offset_coord(cur_wp.x, reach);
                py    = offset_coord(cur_wp.y, reach);
            end else if (pick < 7 && tgt + 1 < sb.active_count()) begin
                next_wp = sb.route_tab[tgt + 1];
                reach   = $urandom_range(0, 2000);
                px      = offset_coord(next_wp.x, reach);
                py      = offset_coord(next_wp.y, reach);
            end else if (pick == 7) begin
                px = clamp_coord(longint'(cur_wp.x) + longint'(cur_wp.tol));
                py = cur_wp.y;
            end
        end
        drive_item(wps_pkg::OP_POS, wps_pkg::ENTRY_W'($urandom), px, py,
                   wps_pkg::TOL_W'($urandom));
    endtask

    task automatic send_random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (sb.finished && pick < 50)
            drive_item(wps_pkg::OP_RESTART, wps_pkg::ENTRY_W'($urandom), rand_coord(),
                       rand_coord(), rand_tol());
        else if (pick < 80)
            send_fix();
        else if (pick < 93)
            drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'($urandom), rand_coord(),
                       rand_coord(), rand_tol());
        else if (pick < 96)
            drive_item(wps_pkg::OP_RESTART, wps_pkg::ENTRY_W'($urandom), rand_coord(),
                       rand_coord(), rand_tol());
        else
            drive_item(OP_UNUSED, wps_pkg::ENTRY_W'($urandom), rand_coord(), rand_coord(),
                       rand_tol());
    endtask

    initial begin
        sb = new();
        burst_left = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= wps_pkg::OP_LOAD;
        i_entry_index <= '0;
        i_coord_x     <= '0;
        i_coord_y     <= '0;
        i_tolerance   <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty route, unused op
        drive_item(wps_pkg::OP_POS, '0, COORD_MAX, COORD_MIN, '0);
        drive_item(wps_pkg::OP_POS, '1, COORD_MIN, COORD_MAX, '1);
        drive_item(OP_UNUSED, '1, COORD_MAX, COORD_MAX, '1);
        drive_item(wps_pkg::OP_RESTART, '0, '0, '0, '0);
        drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'(0), COORD_MAX, COORD_MIN, '0);
        drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'(1), COORD_MIN, COORD_MAX, '1);
        drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'(2), '0, '0, wps_pkg::TOL_W'(100));
        drive_item(wps_pkg::OP_LOAD, '1, '1, '1, wps_pkg::TOL_W'(1));
        write_count(3);
        // tie with next-leg length, promotion, arrival, tolerance edge, finish
        drive_item(wps_pkg::OP_POS, '0, COORD_MAX, COORD_MIN, '0);
        drive_item(wps_pkg::OP_POS, '0, COORD_MIN, COORD_MAX, '0);
        drive_item(wps_pkg::OP_POS, '0, COORD_MIN + wps_pkg::t_coord'(65534), COORD_MAX, '0);
        drive_item(wps_pkg::OP_POS, '0, '0, wps_pkg::t_coord'(100), '0);
        drive_item(wps_pkg::OP_POS, '0, '0, wps_pkg::t_coord'(-99), '0);
        drive_item(wps_pkg::OP_POS, '0, '0, '0, '0);
        drive_item(wps_pkg::OP_RESTART, '1, '0, '0, '0);
        drive_item(wps_pkg::OP_POS, '0, '0, '0, '0);
        drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'(2), COORD_MIN + wps_pkg::t_coord'(10),
                   COORD_MAX, '0);
        drive_item(wps_pkg::OP_POS, '0, COORD_MIN + wps_pkg::t_coord'(10), COORD_MAX, '0);
        write_count(2);
        drive_item(wps_pkg::OP_POS, '0, '0, '0, '0);
        drive_item(wps_pkg::OP_RESTART, '0, '0, '0, '0);
        write_count(1);
        drive_item(wps_pkg::OP_POS, '0, COORD_MAX, COORD_MIN, '0);
        drive_item(wps_pkg::OP_LOAD, wps_pkg::ENTRY_W'(0), COORD_MAX, COORD_MIN,
                   wps_pkg::TOL_W'(1));
        drive_item(wps_pkg::OP_POS, '0, COORD_MAX, COORD_MIN, '0);

        foreach (phase_counts[p]) begin
            write_count(phase_counts[p]);
            drive_item(wps_pkg::OP_RESTART, '0, '0, '0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20) begin
                    // results held off while fixes keep coming
                    hold_req   = 1'b1;
                    burst_left = 16;
                    repeat (16) send_fix();
                end
                if (p == 3 && n == 30) wait_drained();
                send_random_item();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("waypoint_sequencer test passed");
        end else begin
            $display("waypoint_sequencer test failed");
        end
        $finish;
    end

endmodule
